@@ src/lsb_stego_extractor_unit_macros.svh @@
// assertion helpers for the checker file
`ifndef LSB_STEGO_EXTRACTOR_UNIT_MACROS_SVH
`define LSB_STEGO_EXTRACTOR_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define LSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define LSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lse_pkg.sv @@
`default_nettype none
package lse_pkg;

  localparam int PIXEL_COUNT_BITS_DEF = 24;

  localparam int WIN_BYTES = 6;
  localparam logic [47:0] DELIM_WORD = 48'h242340253626;

  // result queue, power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } result_t;

  // up to two results from one pixel, r0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage
`default_nettype wire

@@ src/lse_step.sv @@
`default_nettype none
module lse_step #(
  parameter int PIXEL_COUNT_BITS = lse_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [2:0]                trio,
  input  logic [PIXEL_COUNT_BITS:0] pixel_count,
  output lse_pkg::push_t            push
);

  localparam int W = PIXEL_COUNT_BITS + 1;

  logic [6:0]   partial_bits;
  logic [2:0]   bits_held;
  logic [47:0]  byte_window;
  logic [2:0]   window_fill;
  logic [W-1:0] pixels_seen;
  logic         finished;

  logic [W-1:0] pc;
  logic [W-1:0] seen;
  logic         bad;
  logic         is_last;
  logic         pack;
  logic [9:0]   acc;
  logic [3:0]   held;
  logic [1:0]   extra;
  logic         byte_done;
  logic [7:0]   new_byte;
  logic [9:0]   rem;
  logic [47:0]  window_shift;
  logic         emit_old;
  logic         found;
  logic         e_end;
  lse_pkg::result_t res_byte;
  lse_pkg::result_t res_stat;

  always_comb begin
    pc = (pixel_count == '0) ? W'(1) : pixel_count;
    bad = pc[2:0] != 3'd0;
    seen = pixels_seen + W'(1);
    is_last = seen >= pc;
    pack = !finished && !bad;

    acc = {partial_bits, trio};
    held = {1'b0, bits_held} + 4'd3;
    byte_done = held >= 4'd8;
    // held stays below 11, so held - 8 is its low two bits
    extra = held[1:0];
    new_byte = 8'(acc >> extra);
    rem = acc & ((10'd1 << extra) - 10'd1);

    window_shift = {byte_window[39:0], new_byte};
    emit_old = pack && byte_done && (window_fill >= 3'(lse_pkg::WIN_BYTES));
    found = pack && byte_done && (window_fill >= 3'(lse_pkg::WIN_BYTES - 1)) &&
            (window_shift == lse_pkg::DELIM_WORD);
    e_end = is_last && (bad || !(finished || found));

    res_byte.kind = lse_pkg::KIND_BYTE;
    res_byte.data_byte = byte_window[47:40];
    res_byte.status = lse_pkg::STATUS_FOUND;
    res_byte.last = 1'b0;

    res_stat.kind = lse_pkg::KIND_STATUS;
    res_stat.data_byte = 8'd0;
    res_stat.last = 1'b1;
    if (found) begin
      res_stat.status = lse_pkg::STATUS_FOUND;
    end else if (bad) begin
      res_stat.status = lse_pkg::STATUS_BAD_LEN;
    end else begin
      res_stat.status = lse_pkg::STATUS_NOT_FOUND;
    end

    // found and end status never come together
    push.r0 = emit_old ? res_byte : res_stat;
    push.r1 = res_stat;
    if (!go) begin
      push.n = 2'd0;
    end else begin
      push.n = {1'b0, emit_old} + {1'b0, found || e_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_bits <= '0;
      bits_held <= '0;
      byte_window <= '0;
      window_fill <= '0;
      pixels_seen <= '0;
      finished <= 1'b0;
    end else if (go) begin
      if (is_last) begin
        partial_bits <= '0;
        bits_held <= '0;
        byte_window <= '0;
        window_fill <= '0;
        pixels_seen <= '0;
        finished <= 1'b0;
      end else begin
        pixels_seen <= seen;
        if (pack) begin
          if (byte_done) begin
            partial_bits <= rem[6:0];
            bits_held <= {1'b0, extra};
            byte_window <= window_shift;
            if (window_fill < 3'(lse_pkg::WIN_BYTES)) begin
              window_fill <= window_fill + 3'd1;
            end
            if (found) begin
              finished <= 1'b1;
            end
          end else begin
            partial_bits <= acc[6:0];
            bits_held <= held[2:0];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/lse_queue.sv @@
`default_nettype none
module lse_queue (
  input  logic             clk,
  input  logic             rst,
  input  lse_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output lse_pkg::result_t head
);

  localparam int DEPTH = lse_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lse_pkg::result_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign out_valid = count != '0;
  assign pop = out_valid && !out_stall;
  // space for the largest burst one pixel can cause
  assign room = count <= CW'(DEPTH - 2);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push.n) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

@@ src/lsb_stego_extractor_unit.sv @@
// path: a transferred pixel waits in the input register until the queue has room, then its results go to the queue
// throughput: one pixel per cycle while the result queue has room; a pixel with two results holds
//   the single output port for both, and a four-entry result queue absorbs the burst
// reset: synchronous, clears image state and result queue; pixel_count returns to 1
// no clearing pass: the block takes pixels from the first cycle after reset
`default_nettype none
module lsb_stego_extractor_unit #(
  parameter int PIXEL_COUNT_BITS = lse_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [PIXEL_COUNT_BITS:0] pixel_count,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                first_channel,
  input  logic [7:0]                second_channel,
  input  logic [7:0]                third_channel,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      kind,
  output logic [7:0]                data_byte,
  output logic [1:0]                status,
  output logic                      last
);

  logic [PIXEL_COUNT_BITS:0] image_pixels;
  logic                      pix_valid;
  logic [2:0]                pix_trio;
  logic                      room;
  logic                      go;
  logic                      accept;
  lse_pkg::push_t            push;
  lse_pkg::result_t          head;

  assign cfg_ready = 1'b1;
  assign go = pix_valid && room;
  assign in_stall = pix_valid && !room;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_pixels <= {{PIXEL_COUNT_BITS{1'b0}}, 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      image_pixels <= pixel_count;
    end
  end

  // input register, only the channel lsbs matter
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (accept) begin
      pix_valid <= 1'b1;
    end else if (go) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_trio <= {first_channel[0], second_channel[0], third_channel[0]};
    end
  end

  lse_step #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .trio       (pix_trio),
    .pixel_count(image_pixels),
    .push       (push)
  );

  lse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign kind = head.kind;
  assign data_byte = head.data_byte;
  assign status = head.status;
  assign last = head.last;

endmodule
`default_nettype wire

@@ src/lse_checker.sv @@
`default_nettype none
`include "lsb_stego_extractor_unit_macros.svh"
module lse_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [7:0] data_byte,
  input logic [1:0] status,
  input logic       last
);

  `LSE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte) && $stable(status) && $stable(last), "stalled result changed")

  `LSE_ASSERT(a_byte_fields, out_valid && kind == lse_pkg::KIND_BYTE |-> status == lse_pkg::STATUS_FOUND && !last, "byte result carries status or last")

  `LSE_ASSERT(a_status_fields, out_valid && kind == lse_pkg::KIND_STATUS |-> last && data_byte == 8'd0 && (status == lse_pkg::STATUS_FOUND || status == lse_pkg::STATUS_NOT_FOUND || status == lse_pkg::STATUS_BAD_LEN), "malformed status result")

  `LSE_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result shown right after reset")

endmodule

bind lsb_stego_extractor_unit lse_checker u_lse_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .kind     (kind),
  .data_byte(data_byte),
  .status   (status),
  .last     (last)
);
`default_nettype wire

@@ dv/tb_lsb_stego_extractor_unit.sv @@
module tb_lsb_stego_extractor_unit;
  import lse_pkg::*;

  localparam int CNT_W      = PIXEL_COUNT_BITS_DEF + 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 400;
  localparam int RANDOM_PIXELS = 1200;

  localparam result_t END_FOUND   = '{KIND_STATUS, 8'h00, STATUS_FOUND, 1'b1};
  localparam result_t END_MISSING = '{KIND_STATUS, 8'h00, STATUS_NOT_FOUND, 1'b1};
  localparam result_t END_BAD_LEN = '{KIND_STATUS, 8'h00, STATUS_BAD_LEN, 1'b1};

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

  typedef struct packed {
    logic             cfg_row;
    logic [CNT_W-1:0] cfg_value;
    logic [7:0]       ch0;
    logic [7:0]       ch1;
    logic [7:0]       ch2;
    logic             typed;
    result_t          want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] pixel_count = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       first_channel = 8'h00;
  logic [7:0]       second_channel = 8'h00;
  logic [7:0]       third_channel = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             kind;
  logic [7:0]       data_byte;
  logic [1:0]       status;
  logic             last;

  lsb_stego_extractor_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pixel_count(pixel_count),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_channel(first_channel), .second_channel(second_channel),
    .third_channel(third_channel),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .data_byte(data_byte), .status(status), .last(last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // extractor image state, mirrored from the block
  logic [CNT_W-1:0] count_reg = 1;
  logic [6:0]       partial_bits = '0;
  logic [2:0]       bits_held = '0;
  logic [47:0]      byte_window = '0;
  logic [2:0]       window_fill = '0;
  logic [CNT_W-1:0] pixels_seen = '0;
  logic             delim_found = 1'b0;

  result_t     extract_results_due[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  logic        squeeze_req = 1'b0;
  logic        squeeze_done = 1'b0;
  int          hold_left = 0;
  logic [7:0]  stall_phase = '0;
  stall_mode_t stall_mode = STALL_NONE;

  // offer one pixel, wait for its transfer, then work out what it yields
  task automatic feed_pixel(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
                            input logic typed, input result_t want);
    int               gap;
    logic             stalled;
    logic [CNT_W-1:0] pc;
    logic [CNT_W-1:0] nxt;
    logic             bad;
    logic             ends;
    logic [9:0]       acc;
    logic [3:0]       held;
    logic [3:0]       extra;
    logic [7:0]       byt;
    result_t          r0;
    result_t          r1;
    int               n;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid       <= 1'b1;
    first_channel  <= c0;
    second_channel <= c1;
    third_channel  <= c2;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    burst_left--;

    n  = 0;
    r0 = '0;
    r1 = '0;
    pc = (count_reg == 0) ? 1 : count_reg;
    bad = (pc[2:0] != 3'd0);
    nxt = pixels_seen + 1'b1;
    ends = (nxt >= pc);
    if (!delim_found && !bad) begin
      acc  = {partial_bits, c0[0], c1[0], c2[0]};
      held = {1'b0, bits_held} + 4'd3;
      if (held >= 4'd8) begin
        extra = held - 4'd8;
        byt   = 8'(acc >> extra);
        acc   = acc & ((10'd1 << extra) - 10'd1);
        held  = extra;
        // a full window pushes its oldest byte out
        if (window_fill >= 3'(WIN_BYTES)) begin
          r0 = '{KIND_BYTE, byte_window[47:40], 2'd0, 1'b0};
          n  = 1;
        end
        byte_window = {byte_window[39:0], byt};
        if (window_fill < 3'(WIN_BYTES)) window_fill = window_fill + 3'd1;
        if (window_fill >= 3'(WIN_BYTES) && byte_window == DELIM_WORD) begin
          delim_found = 1'b1;
          if (n == 0) r0 = END_FOUND;
          else r1 = END_FOUND;
          n++;
        end
      end
      partial_bits = acc[6:0];
      bits_held    = held[2:0];
    end
    if (ends) begin
      if (bad || !delim_found) begin
        if (n == 0) r0 = bad ? END_BAD_LEN : END_MISSING;
        else r1 = bad ? END_BAD_LEN : END_MISSING;
        n++;
      end
      partial_bits = '0;
      bits_held    = '0;
      byte_window  = '0;
      window_fill  = '0;
      pixels_seen  = '0;
      delim_found  = 1'b0;
    end else begin
      pixels_seen = nxt;
    end

    if (typed) begin
      extract_results_due.push_back(want);
    end else begin
      if (n > 0) extract_results_due.push_back(r0);
      if (n > 1) extract_results_due.push_back(r1);
    end
  endtask

  // stop offering and let every owed result and the pipeline drain
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (extract_results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_pixel_count(input logic [CNT_W-1:0] value);
    logic ready_seen;
    cfg_valid   <= 1'b1;
    pixel_count <= value;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
    count_reg = value;
  endtask

  // receiver: changing stall patterns, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase[5:0] == 6'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (squeeze_req && !squeeze_done) begin
        hold_left    <= HOLD_LEN;
        squeeze_done <= 1'b1;
        out_stall    <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= stall_phase[2];
        endcase
      end
    end
  end

  // sample at the falling edge, where every transfer of the next edge is settled
  always @(negedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_valid && !out_stall) begin
        got = '{kind, data_byte, status, last};
        if (extract_results_due.size() == 0) begin
          $error("result with nothing owed: kind %0d byte %h status %0d last %0d",
                 kind, data_byte, status, last);
          error_count++;
        end else begin
          want = extract_results_due.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            error_count++;
          end
          if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %h, actual %h", want.data_byte, got.data_byte);
            error_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            error_count++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    bit        msg_bits[$];
    int        random_pixels;
    int        pick;
    int        msg_len;
    int        needed;
    int        pc;
    logic [7:0] b;

    // directed: reset length, zero length, short image, delimiter on the final pixel
    plan.push_back('{1'b0, '0, 8'hff, 8'hff, 8'hff, 1'b1, END_BAD_LEN});
    plan.push_back('{1'b1, CNT_W'(0), 8'h00, 8'h00, 8'h00, 1'b0, '0});
    plan.push_back('{1'b0, '0, 8'hfe, 8'h01, 8'h80, 1'b1, END_BAD_LEN});
    plan.push_back('{1'b1, CNT_W'(8), 8'h00, 8'h00, 8'h00, 1'b0, '0});
    for (int p = 0; p < 8; p++)
      plan.push_back('{1'b0, '0, (p % 2 == 1) ? 8'hff : 8'h00, (p % 3 == 0) ? 8'h7f : 8'h80,
                       8'(p * 37), (p == 7), END_MISSING});
    plan.push_back('{1'b1, CNT_W'(16), 8'h00, 8'h00, 8'h00, 1'b0, '0});
    for (int p = 0; p < 16; p++)
      plan.push_back('{1'b0, '0, {7'($urandom), DELIM_WORD[47 - 3 * p]},
                       {7'($urandom), DELIM_WORD[46 - 3 * p]},
                       {7'($urandom), DELIM_WORD[45 - 3 * p]}, (p == 15), END_FOUND});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg_row) begin
        drain();
        write_pixel_count(plan[i].cfg_value);
      end else begin
        feed_pixel(plan[i].ch0, plan[i].ch1, plan[i].ch2, plan[i].typed, plan[i].want);
      end
    end

    // widest counts; each image is cut short by a smaller count written mid-image
    drain();
    write_pixel_count({CNT_W{1'b1}});
    repeat (20) feed_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    drain();
    write_pixel_count(CNT_W'(8));
    feed_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    drain();
    write_pixel_count(CNT_W'(1) << PIXEL_COUNT_BITS_DEF);
    squeeze_req <= 1'b1;
    repeat (300) feed_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    drain();
    write_pixel_count(CNT_W'(24));
    feed_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 9);
      msg_bits.delete();
      if (pick <= 5) begin
        // hidden message followed by the delimiter
        msg_len = $urandom_range(0, 10);
        repeat (msg_len) begin
          b = 8'($urandom);
          for (int k = 7; k >= 0; k--) msg_bits.push_back(b[k]);
        end
        for (int k = 47; k >= 0; k--) msg_bits.push_back(DELIM_WORD[k]);
        needed = (msg_bits.size() + 2) / 3;
        if ($urandom_range(0, 4) == 0)
          pc = 8 * $urandom_range(1, needed / 8 + 1);
        else
          pc = 8 * ((needed + 7) / 8 + $urandom_range(0, 2));
      end else if (pick <= 7) begin
        pc = 8 * $urandom_range(1, 6);
      end else if (pick == 8) begin
        pc = 8 * $urandom_range(0, 4) + $urandom_range(1, 7);
      end else begin
        pc = (count_reg == 0) ? 1 : int'(count_reg);
      end
      while (msg_bits.size() < 3 * pc) msg_bits.push_back(1'($urandom));
      if (pick != 9) begin
        drain();
        write_pixel_count(CNT_W'(pc));
      end
      for (int p = 0; p < pc; p++) begin
        feed_pixel({7'($urandom), msg_bits[3 * p]}, {7'($urandom), msg_bits[3 * p + 1]},
                   {7'($urandom), msg_bits[3 * p + 2]}, 1'b0, '0);
        random_pixels++;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0 && extract_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (extract_results_due.size() != 0)
        $error("%0d results never arrived", extract_results_due.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
